// ===== rtl/core/bfss_pkg.sv =====
`default_nettype none

package bfss_pkg;

  // Word size of the store and the bits that pick a bit inside a word
  localparam int WORD_BITS = 32;
  localparam int OFF_BITS  = 5;

  // Item modes
  localparam logic [2:0] MODE_WRITE_AT = 3'd0;
  localparam logic [2:0] MODE_APPEND   = 3'd1;
  localparam logic [2:0] MODE_READ_AT  = 3'd2;
  localparam logic [2:0] MODE_READ_PTR = 3'd3;
  localparam logic [2:0] MODE_SET      = 3'd4;
  localparam logic [2:0] MODE_ADVANCE  = 3'd5;
  localparam logic [2:0] MODE_RETREAT  = 3'd6;

  // Request transaction
  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] bit_position;
    logic [31:0] write_data;
    logic [5:0]  bit_count;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] pointer_value;
    logic        out_of_range;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/bfss_ram.sv =====
`default_nettype none

module bfss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/bit_field_stream_store.sv =====
// Bit field stream store.
// A word store of STORE_WORDS 32-bit words plus a bit pointer; bits are
// numbered LSB-first. Each request transaction (req, req_valid/req_stall)
// writes, appends, or reads a field of 0 to 32 bits, or sets, advances or
// retreats the pointer. Each request gives exactly one response transaction
// (rsp, rsp_valid/rsp_stall) with the read field, the pointer after the
// request and an out-of-range flag for accesses past the store end.
// The store is split into an even-word and an odd-word bank, so a field
// that straddles two words reads both words together and writes both
// back together. A request reads the banks on the accept edge and does the
// read-modify-write in the modify stage after it; a new request is taken
// only when the modify stage is free: one bank pass at a time.
// The response is registered; while the receiver stalls it, one more
// request is taken and held in the modify stage until the response drains.
// Reset clears the pointer and starts a clearing pass that zeroes the banks,
// one row of each per cycle over all (STORE_WORDS + 1) / 2 rows, with
// req_stall held high throughout.
`default_nettype none

module bit_field_stream_store
  import bfss_pkg::*;
#(
  parameter int STORE_WORDS = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int HALF  = (STORE_WORDS + 1) / 2;
  localparam int BW    = HALF > 1 ? $clog2(HALF) : 1;
  localparam int PTR_W = $clog2(STORE_WORDS * WORD_BITS + 1);
  localparam int SUM_W = (PTR_W > 16 ? PTR_W : 16) + 1;
  localparam logic [SUM_W-1:0] CAP_BITS = SUM_W'(STORE_WORDS * WORD_BITS);

  // Control state
  logic            clearing;
  logic [BW-1:0]   clr_idx;
  logic            busy;
  logic [PTR_W-1:0] ptr;

  // Modify stage payload
  logic            s_rd;
  logic            s_wr;
  logic            s_odd;
  logic            s_oor;
  logic [OFF_BITS-1:0] s_off;
  logic [63:0]     s_mask;
  logic [63:0]     s_wval;
  logic [BW-1:0]   s_even_addr;
  logic [BW-1:0]   s_odd_addr;
  logic [15:0]     s_ptr16;

  // Accept-side decode
  logic             accept;
  logic [5:0]       n;
  logic             at_ptr;
  logic             is_wr;
  logic             is_rd;
  logic             fit;
  logic [SUM_W-1:0] ptr_ext;
  logic [SUM_W-1:0] pos_ext;
  logic [SUM_W-1:0] addr_ext;
  logic [SUM_W-1:0] wsel;
  logic [SUM_W-1:0] adv_sum;
  logic [SUM_W-1:0] ptr_next_ext;
  logic [31:0]      len_mask;
  logic [63:0]      mask64;
  logic [63:0]      wval64;

  // Modify-side signals
  logic        drain;
  logic [31:0] even_rdata;
  logic [31:0] odd_rdata;
  logic [31:0] lo_word;
  logic [31:0] hi_word;
  logic [63:0] pair;
  logic [63:0] field64;
  logic [63:0] merged;
  logic        lo_any;
  logic        hi_any;
  logic        bank_re;
  logic        even_we;
  logic        odd_we;
  logic [BW-1:0] even_waddr;
  logic [BW-1:0] odd_waddr;
  logic [31:0] even_wdata;
  logic [31:0] odd_wdata;
  logic [31:0] rd_field;

  assign req_stall = clearing || busy;
  assign accept    = req_valid && !req_stall;
  assign drain     = busy && (!rsp_valid || !rsp_stall);
  assign ptr_ext   = SUM_W'(ptr);

  // Decode the request, check the bounds and work out the new pointer
  always_comb begin
    n        = req.bit_count[5] ? 6'd32 : req.bit_count;
    at_ptr   = (req.mode == MODE_APPEND) || (req.mode == MODE_READ_PTR);
    is_wr    = (req.mode == MODE_WRITE_AT) || (req.mode == MODE_APPEND);
    is_rd    = (req.mode == MODE_READ_AT) || (req.mode == MODE_READ_PTR);
    pos_ext  = SUM_W'(req.bit_position);
    addr_ext = at_ptr ? ptr_ext : pos_ext;
    fit      = (addr_ext + SUM_W'(n)) <= CAP_BITS;
    wsel     = addr_ext >> OFF_BITS;
    len_mask = (n == 6'd32) ? 32'hFFFF_FFFF : ((32'd1 << n[4:0]) - 32'd1);
    mask64   = {32'd0, len_mask} << addr_ext[OFF_BITS-1:0];
    wval64   = {32'd0, req.write_data & len_mask} << addr_ext[OFF_BITS-1:0];
    adv_sum  = ptr_ext + pos_ext;
    unique case (req.mode)
      MODE_APPEND:  ptr_next_ext = fit ? (ptr_ext + SUM_W'(n)) : ptr_ext;
      MODE_SET:     ptr_next_ext = (pos_ext > CAP_BITS) ? CAP_BITS : pos_ext;
      MODE_ADVANCE: ptr_next_ext = (adv_sum > CAP_BITS) ? CAP_BITS : adv_sum;
      MODE_RETREAT: ptr_next_ext = (pos_ext > ptr_ext) ? '0 : (ptr_ext - pos_ext);
      default:      ptr_next_ext = ptr_ext;
    endcase
  end

  // Read both words of the field on the accept edge
  assign bank_re = accept && (is_wr || is_rd) && fit;

  // Line up the low and high word, extract the field and merge new bits
  always_comb begin
    lo_word  = s_odd ? odd_rdata : even_rdata;
    hi_word  = s_odd ? even_rdata : odd_rdata;
    pair     = {hi_word, lo_word};
    field64  = (pair & s_mask) >> s_off;
    rd_field = s_rd ? field64[31:0] : 32'd0;
    merged   = (pair & ~s_mask) | s_wval;
    lo_any   = |s_mask[31:0];
    hi_any   = |s_mask[63:32];
  end

  // Bank write ports: clearing pass first, then write-back of the field
  always_comb begin
    even_we    = clearing || (drain && s_wr && (s_odd ? hi_any : lo_any));
    odd_we     = clearing || (drain && s_wr && (s_odd ? lo_any : hi_any));
    even_waddr = clearing ? clr_idx : s_even_addr;
    odd_waddr  = clearing ? clr_idx : s_odd_addr;
    even_wdata = clearing ? 32'd0 : (s_odd ? merged[63:32] : merged[31:0]);
    odd_wdata  = clearing ? 32'd0 : (s_odd ? merged[31:0] : merged[63:32]);
  end

  bfss_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(HALF)
  ) u_even_bank (
    .clk  (clk),
    .we   (even_we),
    .waddr(even_waddr),
    .wdata(even_wdata),
    .re   (bank_re),
    .raddr(BW'((wsel + SUM_W'(1)) >> 1)),
    .rdata(even_rdata)
  );

  bfss_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(HALF)
  ) u_odd_bank (
    .clk  (clk),
    .we   (odd_we),
    .waddr(odd_waddr),
    .wdata(odd_wdata),
    .re   (bank_re),
    .raddr(BW'(wsel >> 1)),
    .rdata(odd_rdata)
  );

  // Control: clearing pass, stage occupancy, pointer, response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      busy      <= 1'b0;
      ptr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + BW'(1);
        if (clr_idx == BW'(HALF - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        busy <= 1'b1;
        ptr  <= PTR_W'(ptr_next_ext);
      end else if (drain) begin
        busy <= 1'b0;
      end
      if (drain) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Capture the request into the modify stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s_rd        <= is_rd && fit;
      s_wr        <= is_wr && fit;
      s_oor       <= (is_rd || is_wr) && !fit;
      s_odd       <= wsel[0];
      s_off       <= addr_ext[OFF_BITS-1:0];
      s_mask      <= mask64;
      s_wval      <= wval64;
      s_even_addr <= BW'((wsel + SUM_W'(1)) >> 1);
      s_odd_addr  <= BW'(wsel >> 1);
      s_ptr16     <= ptr_next_ext[15:0];
    end
  end

  // Load the response register when the stage drains
  always_ff @(posedge clk) begin
    if (drain) begin
      rsp.read_data     <= rd_field;
      rsp.pointer_value <= s_ptr16;
      rsp.out_of_range  <= s_oor;
    end
  end

  // An accepted request occupies the modify stage on the next cycle
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("stage not occupied after accept");

  // A new response only appears out of an occupied stage
  assert property (@(posedge clk) disable iff (rst) $rose(rsp_valid) |-> $past(busy))
    else $error("response without request");

  // A dropped access returns no data
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.out_of_range && (rsp.read_data != 32'd0)))
    else $error("out-of-range response carries data");

  // The pointer stays within the capacity
  assert property (@(posedge clk) disable iff (rst) ptr_ext <= CAP_BITS)
    else $error("pointer beyond capacity");

  // Banks are written only by the clearing pass or a draining write
  assert property (@(posedge clk) disable iff (rst)
    (even_we || odd_we) |-> (clearing || (drain && s_wr)))
    else $error("stray bank write");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bfss_pkg::*;

  localparam int STORE_WORDS = 1024;
  localparam int CAPACITY = STORE_WORDS * WORD_BITS;
  localparam int ITEM_TARGET = 1250;
  localparam int PHASE_ITEMS = 150;
  localparam int MAX_IDLE = 18;
  localparam int SETTLE_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef enum int {PACE_MIXED, PACE_FREE, PACE_SLOW_SINK, PACE_SLOW_SOURCE} pace_e;

  // Store and pointer predictor plus the queue of responses still owed
  class field_store_scoreboard #(int WORDS = 1024);
    localparam int unsigned CAP_BITS = WORDS * WORD_BITS;
    bit [31:0] words [WORDS];
    int unsigned pointer;
    rsp_t expected_rsp [$];
    int unsigned mismatches;

    function void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (mismatches < 10)
        $display("mismatch %s: expected %h, got %h", what, want, got);
      mismatches++;
    endfunction

    // Apply one accepted request transaction and queue the response it owes
    function void note_request(req_t r);
      rsp_t e;
      int unsigned n, addr, w, off;
      bit [63:0] mask, pair;
      bit fits;
      n = (r.bit_count > WORD_BITS) ? WORD_BITS : r.bit_count;
      mask = (n >= WORD_BITS) ? 64'hFFFF_FFFF : ((64'd1 << n) - 64'd1);
      addr = (r.mode == MODE_APPEND || r.mode == MODE_READ_PTR) ? pointer : r.bit_position;
      w = addr / WORD_BITS;
      off = addr % WORD_BITS;
      fits = (addr + n <= CAP_BITS);
      pair = '0;
      if (w < WORDS) pair[31:0] = words[w];
      if (w + 1 < WORDS) pair[63:32] = words[w + 1];
      e = '0;
      unique case (r.mode)
        MODE_WRITE_AT, MODE_APPEND: begin
          if (!fits) begin
            e.out_of_range = 1'b1;
          end else begin
            // merge the field into the word pair, the second word may not exist
            pair = (pair & ~(mask << off)) | ((64'(r.write_data) & mask) << off);
            if (w < WORDS) words[w] = pair[31:0];
            if (w + 1 < WORDS) words[w + 1] = pair[63:32];
            if (r.mode == MODE_APPEND) pointer += n;
          end
        end
        MODE_READ_AT, MODE_READ_PTR: begin
          if (!fits) e.out_of_range = 1'b1;
          else e.read_data = 32'((pair >> off) & mask);
        end
        MODE_SET: begin
          pointer = (r.bit_position > CAP_BITS) ? CAP_BITS : r.bit_position;
        end
        MODE_ADVANCE: begin
          pointer = (pointer + r.bit_position > CAP_BITS) ? CAP_BITS
                                                          : pointer + r.bit_position;
        end
        MODE_RETREAT: begin
          pointer = (r.bit_position > pointer) ? 0 : pointer - r.bit_position;
        end
        default: ;
      endcase
      e.pointer_value = 16'(pointer);
      expected_rsp.push_back(e);
    endfunction

    // Compare one accepted response transaction with the oldest one owed
    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        note_mismatch("response with nothing outstanding, read_data", '0, got.read_data);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.read_data !== want.read_data)
        note_mismatch("read_data", want.read_data, got.read_data);
      if (got.pointer_value !== want.pointer_value)
        note_mismatch("pointer_value", 32'(want.pointer_value), 32'(got.pointer_value));
      if (got.out_of_range !== want.out_of_range)
        note_mismatch("out_of_range", 32'(want.out_of_range), 32'(got.out_of_range));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  field_store_scoreboard #(STORE_WORDS) sb;
  pace_e pace = PACE_MIXED;
  int sent = 0;
  int unsigned cycle_count = 0;

  bit_field_stream_store #(.STORE_WORDS(STORE_WORDS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int sender_gap();
    return (pace == PACE_FREE || pace == PACE_SLOW_SINK) ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic int receiver_stall();
    return (pace == PACE_FREE || pace == PACE_SLOW_SOURCE) ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic req_t make_request(logic [2:0] mode, logic [15:0] pos,
                                        logic [31:0] data, logic [5:0] count);
    req_t r;
    r.mode = mode;
    r.bit_position = pos;
    r.write_data = data;
    r.bit_count = count;
    return r;
  endfunction

  // Favor the low end and the top end of the store, where fields get reused
  function automatic logic [15:0] pick_address();
    unique case ($urandom_range(0, 6))
      0, 1, 2: return 16'($urandom_range(0, 511));
      3, 4:    return 16'(CAPACITY - $urandom_range(0, 300));
      5:       return 16'($urandom_range(0, CAPACITY));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [5:0] pick_count();
    unique case ($urandom_range(0, 9))
      0:       return 6'($urandom_range(0, 63));
      1:       return 6'd32;
      default: return 6'($urandom_range(1, 32));
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    if ($urandom_range(0, 3) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 96));
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.mode = 3'($urandom_range(0, 7));
    r.write_data = $urandom();
    r.bit_count = pick_count();
    if (r.mode == MODE_ADVANCE || r.mode == MODE_RETREAT) r.bit_position = pick_step();
    else r.bit_position = pick_address();
    return r;
  endfunction

  // Drive one request transaction; valid stays high until the next negedge
  task automatic send_request(input req_t r);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_request(r);
    sent++;
  endtask

  // Hold off the sender until every owed response has come back
  task automatic drain_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    while (sb.expected_rsp.size() != 0) @(posedge clk);
  endtask

  // Append a run of fields, rewind, and read them back at the pointer
  task automatic stream_sequence();
    logic [5:0] lens [8];
    logic [15:0] start;
    int k, total;
    start = pick_address();
    k = $urandom_range(2, 8);
    total = 0;
    send_request(make_request(MODE_SET, start, $urandom(), pick_count()));
    for (int i = 0; i < k; i++) begin
      lens[i] = pick_count();
      total += (lens[i] > WORD_BITS) ? WORD_BITS : lens[i];
      send_request(make_request(MODE_APPEND, 16'($urandom()), $urandom(), lens[i]));
    end
    if ($urandom_range(0, 1) == 0)
      send_request(make_request(MODE_SET, start, $urandom(), pick_count()));
    else
      send_request(make_request(MODE_RETREAT, 16'(total), $urandom(), pick_count()));
    for (int i = 0; i < k; i++) begin
      send_request(make_request(MODE_READ_PTR, 16'($urandom()), $urandom(), lens[i]));
      send_request(make_request(MODE_ADVANCE,
                                (lens[i] > WORD_BITS) ? 16'(WORD_BITS) : 16'(lens[i]),
                                $urandom(), pick_count()));
    end
  endtask

  // Edge cases: straddling fields, store end, zero and oversize lengths
  task automatic directed_items();
    send_request(make_request(MODE_READ_AT, 16'd0, 32'h0, 6'd32));
    send_request(make_request(MODE_WRITE_AT, 16'd0, 32'hDEAD_BEEF, 6'd32));
    send_request(make_request(MODE_WRITE_AT, 16'd30, 32'hFFFF_FFA5, 6'd8));
    send_request(make_request(MODE_READ_AT, 16'd28, 32'h0, 6'd12));
    send_request(make_request(MODE_READ_AT, 16'd0, 32'hFFFF_FFFF, 6'd32));
    send_request(make_request(MODE_APPEND, 16'hFFFF, 32'h0000_0015, 6'd5));
    send_request(make_request(MODE_APPEND, 16'd0, 32'hFFFF_FFFF, 6'd0));
    send_request(make_request(MODE_APPEND, 16'd0, 32'h8765_4321, 6'd45));
    send_request(make_request(MODE_READ_PTR, 16'd0, 32'h0, 6'd7));
    send_request(make_request(MODE_SET, 16'd40000, 32'h0, 6'd1));
    send_request(make_request(MODE_READ_PTR, 16'd0, 32'h0, 6'd1));
    send_request(make_request(MODE_APPEND, 16'd0, 32'hFFFF_FFFF, 6'd0));
    send_request(make_request(MODE_RETREAT, 16'hFFFF, 32'h0, 6'd63));
    send_request(make_request(MODE_ADVANCE, 16'hFFFF, 32'h0, 6'd1));
    send_request(make_request(MODE_RETREAT, 16'd32, 32'h0, 6'd1));
    send_request(make_request(MODE_APPEND, 16'd0, 32'hFFFF_FFFF, 6'd32));
    send_request(make_request(MODE_READ_AT, 16'(CAPACITY - 32), 32'h0, 6'd32));
    send_request(make_request(MODE_WRITE_AT, 16'(CAPACITY - 28), 32'h1234_5678, 6'd32));
    send_request(make_request(MODE_READ_AT, 16'hFFFF, 32'h0, 6'd63));
    send_request(make_request(MODE_WRITE_AT, 16'(CAPACITY - 1), 32'hFFFF_FFFE, 6'd1));
    send_request(make_request(MODE_READ_AT, 16'(CAPACITY - 1), 32'h0, 6'd1));
    send_request(make_request(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 6'd63));
    send_request(make_request(MODE_READ_AT, 16'(CAPACITY), 32'h0, 6'd0));
    send_request(make_request(MODE_WRITE_AT, 16'd100, 32'hFFFF_FFFF, 6'd0));
    send_request(make_request(MODE_SET, 16'd0, 32'h0, 6'd0));
  endtask

  // Response side: stall a random number of cycles, then take one response
  initial begin : rsp_side
    int stall;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      stall = receiver_stall();
      if (stall > 0) begin
        rsp_stall <= 1'b1;
        repeat (stall) @(negedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
      sb.check_response(rsp);
      @(negedge clk);
    end
  end

  // Reset, directed items, then random phases with a drain between them
  initial begin : req_side
    int phase_end;
    sb = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_items();
    drain_responses();
    while (sent < ITEM_TARGET) begin
      pace = pace_e'($urandom_range(0, 3));
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end && sent < ITEM_TARGET) begin
        if ($urandom_range(0, 9) < 6) stream_sequence();
        else send_request(random_request());
      end
      drain_responses();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_rsp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/bfss_pkg.sv
rtl/core/bfss_ram.sv
rtl/core/bit_field_stream_store.sv
tb/tb_top.sv
